@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the page-slot cache.
// The including module must provide clk_i and an active-low reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define LPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside of reset.
`define LPSC_ASSERT_NEVER(lbl, cond, msg) \
  `LPSC_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/lpsc_pkg.sv @@
// Shared types and constants of the page-slot cache.
// Used by the channel interfaces, the cache top module and the testbench; depends on nothing.
package lpsc_pkg;

  localparam int unsigned PAGE_W  = 31;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned SEG_W   = 26;
  localparam int unsigned PIS_W   = 5;

  // Request mode codes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REPAIR,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [PAGE_W-1:0] page_number;
    logic [GEN_W-1:0]  generation;
    logic              flush_flag;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              was_invalidated;
    logic [SEG_W-1:0]  segment;
    logic [PIS_W-1:0]  page_in_segment;
  } rsp_t;

endpackage

@@ rtl/core/lpsc_if.sv @@
// Valid/ready channel interfaces for requests and results of the cache.
// Depends on lpsc_pkg for the payload types.
interface lpsc_req_if;
  logic              valid;
  logic              ready;
  lpsc_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpsc_rsp_if;
  logic              valid;
  logic              ready;
  lpsc_pkg::rsp_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/lpsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lpsc_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lpsc_seg_div.sv @@
// Division of the page number by a constant segment size by reciprocal
// multiplication; the quotient is registered first, then the remainder together with done_o.
// No package dependencies.
module lpsc_seg_div #(
  parameter int unsigned DIVISOR    = 32,
  parameter int unsigned DIVIDEND_W = 31,
  parameter int unsigned REM_W      = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o,
  output logic [REM_W-1:0]      rem_o
);

  localparam int unsigned LogD  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int unsigned Shift = DIVIDEND_W + LogD;
  localparam int unsigned RecW  = DIVIDEND_W + 1;
  localparam int unsigned ProdW = DIVIDEND_W + RecW;
  localparam longint unsigned Recip =
      ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecW-1:0]       RecK = RecW'(Recip);
  localparam logic [DIVIDEND_W-1:0] DivK = DIVIDEND_W'(DIVISOR);

  logic [DIVIDEND_W-1:0] num_q, num_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [1:0]            step_q, step_d;
  logic                  done_q, done_d;
  logic [ProdW-1:0]      prod;
  logic [ProdW-1:0]      prod_sh;
  logic [DIVIDEND_W-1:0] back;
  logic [DIVIDEND_W-1:0] diff;

  // Quotient: high part of the dividend times the rounded-up reciprocal.
  assign prod    = ProdW'(num_q) * ProdW'(RecK);
  assign prod_sh = prod >> Shift;
  // Remainder from the registered quotient.
  assign back    = quo_q * DivK;
  assign diff    = num_q - back;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = dividend_i;
      step_d = 2'd2;
      done_d = 1'b0;
    end else if (step_q == 2'd2) begin
      quo_d  = prod_sh[DIVIDEND_W-1:0];
      step_d = 2'd1;
    end else if (step_q == 2'd1) begin
      rem_d  = diff[REM_W-1:0];
      step_d = 2'd0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/lru_page_slot_cache.sv @@
// Page-slot cache with LRU replacement by time stamps; one request in flight.
// Lookup: the slot scan through the RAM read port, a decide step, on eviction a repair
// step for each stamp ahead of the counter, the stamp write and the result step. A clear
// request goes straight to the result step. A new request is taken while a result waits for transfer.
// Reset (async, active low) empties all slots, zeroes the stamp counter and the
// stored generation/flush pair; RAM contents are not cleared.
module lru_page_slot_cache #(
  parameter int unsigned SLOT_COUNT        = 8,
  parameter int unsigned PAGES_PER_SEGMENT = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lpsc_req_if.sink   req_i,
  lpsc_rsp_if.source rsp_o
);

  localparam int unsigned IW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned RemW = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;
  localparam logic [CW-1:0] SlotCnt = CW'(SLOT_COUNT);
  localparam logic [IW-1:0] LastIdx = IW'(SLOT_COUNT - 1);

  // Control state.
  lpsc_pkg::state_e                 state_q, state_d;
  logic [SLOT_COUNT-1:0]            valid_q, valid_d;
  logic [lpsc_pkg::STAMP_W-1:0]     cnt_q, cnt_d;
  logic [lpsc_pkg::GEN_W-1:0]       gen_q, gen_d;
  logic                             flush_q, flush_d;
  logic [CW-1:0]                    idx_q, idx_d;
  logic                             chk_vld_q, chk_vld_d;
  logic                             out_vld_q, out_vld_d;
  logic                             mode_q, mode_d;

  // Per-request working registers.
  logic [lpsc_pkg::PAGE_W-1:0]      page_q, page_d;
  logic                             inval_q, inval_d;
  logic [IW-1:0]                    chk_idx_q, chk_idx_d;
  logic                             hit_q, hit_d;
  logic [IW-1:0]                    hit_idx_q, hit_idx_d;
  logic [lpsc_pkg::STAMP_W-1:0]     best_q, best_d;
  logic [IW-1:0]                    best_idx_q, best_idx_d;
  logic [SLOT_COUNT-1:0]            repair_q, repair_d;
  logic [IW-1:0]                    slot_q, slot_d;
  logic                             miss_q, miss_d;
  lpsc_pkg::rsp_t                   out_q, out_d;

  // RAM ports.
  logic                             rd_en;
  logic                             tag_we, stamp_we;
  logic [IW-1:0]                    waddr;
  logic [lpsc_pkg::PAGE_W-1:0]      tag_rdata;
  logic [lpsc_pkg::STAMP_W-1:0]     stamp_rdata;

  // Helpers.
  logic                             req_ready;
  logic                             div_start, div_done;
  logic [lpsc_pkg::PAGE_W-1:0]      div_quot;
  logic [RemW-1:0]                  div_rem;
  logic [lpsc_pkg::STAMP_W-1:0]     age;
  logic [IW-1:0]                    first_empty, first_rep;
  logic [SLOT_COUNT-1:0]            rep_rest;
  logic [31:0]                      slot_ext, rem_ext;

  // Tag and stamp stores: both read at the scan index, written at waddr.
  lpsc_ram #(
    .WIDTH (lpsc_pkg::PAGE_W),
    .DEPTH (SLOT_COUNT),
    .ADDR_W(IW)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(waddr),
    .wdata_i(page_q),
    .re_i   (rd_en),
    .raddr_i(idx_q[IW-1:0]),
    .rdata_o(tag_rdata)
  );

  lpsc_ram #(
    .WIDTH (lpsc_pkg::STAMP_W),
    .DEPTH (SLOT_COUNT),
    .ADDR_W(IW)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(waddr),
    .wdata_i(cnt_q),
    .re_i   (rd_en),
    .raddr_i(idx_q[IW-1:0]),
    .rdata_o(stamp_rdata)
  );

  // Segment split runs alongside the slot scan.
  lpsc_seg_div #(
    .DIVISOR   (PAGES_PER_SEGMENT),
    .DIVIDEND_W(lpsc_pkg::PAGE_W),
    .REM_W     (RemW)
  ) u_seg_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(req_i.data.page_number),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Lowest empty slot and lowest slot whose stamp needs repair.
  always_comb begin
    first_empty = '0;
    first_rep   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        first_empty = IW'(i);
      end
      if (repair_q[i]) begin
        first_rep = IW'(i);
      end
    end
  end

  // Drop the lowest set bit of the repair mask.
  assign rep_rest = repair_q & (repair_q - SLOT_COUNT'(1));

  // Age of the slot under check; a stamp ahead of the counter counts as age zero.
  assign age = (stamp_rdata > cnt_q) ? '0 : (cnt_q - stamp_rdata);

  assign slot_ext = 32'(slot_q);
  assign rem_ext  = 32'(div_rem);

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    gen_d      = gen_q;
    flush_d    = flush_q;
    idx_d      = idx_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = idx_q[IW-1:0];
    out_vld_d  = out_vld_q;
    mode_d     = mode_q;
    page_d     = page_q;
    inval_d    = inval_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    repair_d   = repair_q;
    slot_d     = slot_q;
    miss_d     = miss_q;
    out_d      = out_q;
    rd_en      = 1'b0;
    tag_we     = 1'b0;
    stamp_we   = 1'b0;
    waddr      = slot_q;
    req_ready  = 1'b0;
    div_start  = 1'b0;

    // Result register: release on transfer.
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    // Evaluate the slot whose tag and stamp arrived this cycle.
    if (chk_vld_q) begin
      if (valid_q[chk_idx_q] && (tag_rdata == page_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = chk_idx_q;
      end
      if (stamp_rdata > cnt_q) begin
        repair_d[chk_idx_q] = 1'b1;
      end
      // Strictly greater keeps the lowest index among equal ages.
      if ((chk_idx_q == '0) || (age > best_q)) begin
        best_d     = age;
        best_idx_d = chk_idx_q;
      end
    end

    case (state_q)
      lpsc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          mode_d   = req_i.data.mode;
          page_d   = req_i.data.page_number;
          hit_d    = 1'b0;
          repair_d = '0;
          idx_d    = '0;
          if (req_i.data.mode == lpsc_pkg::MODE_CLEAR) begin
            // Empty every slot; stored generation and flush flag stay.
            valid_d = '0;
            cnt_d   = '0;
            state_d = lpsc_pkg::ST_DONE;
          end else begin
            if ((req_i.data.generation != gen_q) || (req_i.data.flush_flag != flush_q)) begin
              // Generation or flush change: empty the cache, restart the counter.
              valid_d = '0;
              cnt_d   = lpsc_pkg::STAMP_W'(1);
              gen_d   = req_i.data.generation;
              flush_d = req_i.data.flush_flag;
              inval_d = 1'b1;
            end else begin
              cnt_d   = cnt_q + lpsc_pkg::STAMP_W'(1);
              inval_d = 1'b0;
            end
            div_start = 1'b1;
            state_d   = lpsc_pkg::ST_SCAN;
          end
        end
      end

      lpsc_pkg::ST_SCAN: begin
        // Issue one read per cycle; results are checked in the cycle after.
        if (idx_q < SlotCnt) begin
          rd_en     = 1'b1;
          idx_d     = idx_q + CW'(1);
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q && (chk_idx_q == LastIdx)) begin
          state_d = lpsc_pkg::ST_DECIDE;
        end
      end

      lpsc_pkg::ST_DECIDE: begin
        if (hit_q) begin
          slot_d  = hit_idx_q;
          miss_d  = 1'b0;
          state_d = lpsc_pkg::ST_WRITE;
        end else if (!(&valid_q)) begin
          slot_d  = first_empty;
          miss_d  = 1'b1;
          state_d = lpsc_pkg::ST_WRITE;
        end else begin
          // Evict the oldest; stamps ahead of the counter get repaired first.
          slot_d  = best_idx_q;
          miss_d  = 1'b1;
          state_d = (|repair_q) ? lpsc_pkg::ST_REPAIR : lpsc_pkg::ST_WRITE;
        end
      end

      lpsc_pkg::ST_REPAIR: begin
        stamp_we = 1'b1;
        waddr    = first_rep;
        repair_d = rep_rest;
        if (rep_rest == '0) begin
          state_d = lpsc_pkg::ST_WRITE;
        end
      end

      lpsc_pkg::ST_WRITE: begin
        // Fresh stamp on the chosen slot; on a miss also the tag and valid bit.
        stamp_we = 1'b1;
        tag_we   = miss_q;
        if (miss_q) begin
          valid_d[slot_q] = 1'b1;
        end
        state_d = lpsc_pkg::ST_DONE;
      end

      lpsc_pkg::ST_DONE: begin
        if ((mode_q || div_done) && (!out_vld_q || rsp_o.ready)) begin
          out_vld_d = 1'b1;
          if (mode_q == lpsc_pkg::MODE_CLEAR) begin
            out_d = '0;
          end else begin
            out_d.hit             = hit_q;
            out_d.slot            = slot_ext[lpsc_pkg::SLOT_W-1:0];
            out_d.was_invalidated = inval_q;
            out_d.segment         = div_quot[lpsc_pkg::SEG_W-1:0];
            out_d.page_in_segment = rem_ext[lpsc_pkg::PIS_W-1:0];
          end
          state_d = lpsc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lpsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpsc_pkg::ST_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      gen_q     <= '0;
      flush_q   <= 1'b0;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= lpsc_pkg::MODE_LOOKUP;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      gen_q     <= gen_d;
      flush_q   <= flush_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
      mode_q    <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    inval_q    <= inval_d;
    chk_idx_q  <= chk_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    repair_q   <= repair_d;
    slot_q     <= slot_d;
    miss_q     <= miss_d;
    out_q      <= out_d;
  end

  assign req_i.ready = req_ready;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  `include "assert_macros.svh"

  // A slot just stamped must hold a valid page afterwards.
  `LPSC_ASSERT(a_written_slot_valid, (state_q == lpsc_pkg::ST_WRITE) |=> valid_q[slot_q], "written slot not valid")
  // Repairs only happen on an eviction from a full cache.
  `LPSC_ASSERT(a_repair_on_evict, (state_q == lpsc_pkg::ST_REPAIR) |-> ((&valid_q) && !hit_q), "stamp repair outside eviction")
  // After an invalidation every slot is empty, so no hit can be reported.
  `LPSC_ASSERT_NEVER(a_no_hit_after_inval, rsp_o.valid && rsp_o.data.hit && rsp_o.data.was_invalidated, "hit reported with invalidation")
  // A clear request empties every slot at once.
  `LPSC_ASSERT(a_clear_empties, (req_i.valid && req_i.ready && req_i.data.mode) |=> (valid_q == '0), "clear left a valid slot")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for lru_page_slot_cache: drives page requests over the
// valid/ready channels and checks every result against an in-bench LRU predictor.
// Depends on lpsc_pkg, the channel interfaces in lpsc_if.sv and the cache RTL.
module tb_top;

  localparam int unsigned SLOT_COUNT        = 8;
  localparam int unsigned PAGES_PER_SEGMENT = 32;

  // The longest lookup is an eviction that repairs stamps first.
  localparam int unsigned DRAIN_CYCLES    = 4 * (2 * SLOT_COUNT + 5);
  localparam int unsigned RSP_HOLD_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned WORK_SET_SIZE   = 12;

  logic clk;
  logic rst_n;

  lpsc_req_if req_bus ();
  lpsc_rsp_if rsp_bus ();

  lru_page_slot_cache #(
    .SLOT_COUNT       (SLOT_COUNT),
    .PAGES_PER_SEGMENT(PAGES_PER_SEGMENT)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Clock: period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cache predictor: its own copy of the slot array, stamps and stored pair.
  // ---------------------------------------------------------------------------
  logic [lpsc_pkg::PAGE_W-1:0]  cache_tag   [SLOT_COUNT];
  bit                           cache_valid [SLOT_COUNT];
  logic [lpsc_pkg::STAMP_W-1:0] cache_stamp [SLOT_COUNT];
  logic [lpsc_pkg::STAMP_W-1:0] cache_clock;
  logic [lpsc_pkg::GEN_W-1:0]   cache_gen;
  bit                           cache_flush;

  lpsc_pkg::rsp_t expected_rsp_q[$];
  int   error_count;
  int   report_count;

  // Empty every slot and restart the stamp clock; the stored pair is kept.
  function automatic void empty_all_slots();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cache_valid[i] = 1'b0;
      cache_stamp[i] = '0;
      cache_tag[i]   = '0;
    end
    cache_clock = '0;
  endfunction

  // Apply one request to the predicted cache and return the result it gives.
  function automatic lpsc_pkg::rsp_t predict_cache_access(lpsc_pkg::req_t r);
    lpsc_pkg::rsp_t               res;
    int                           found;
    bit                           have_victim;
    logic [lpsc_pkg::STAMP_W-1:0] age;
    logic [lpsc_pkg::STAMP_W-1:0] best_age;
    logic [31:0]                  seg_full;
    logic [31:0]                  pis_full;
    res         = '0;
    found       = -1;
    have_victim = 1'b0;
    best_age    = '0;
    if (r.mode == lpsc_pkg::MODE_CLEAR) begin
      empty_all_slots();
      return res;
    end
    // A new generation or flush state invalidates the whole cache first.
    if (r.generation != cache_gen || r.flush_flag != cache_flush) begin
      empty_all_slots();
      cache_gen           = r.generation;
      cache_flush         = r.flush_flag;
      res.was_invalidated = 1'b1;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (found < 0 && cache_valid[i] && cache_tag[i] == r.page_number) found = i;
    end
    cache_clock = cache_clock + 1'b1;
    if (found >= 0) begin
      res.hit = 1'b1;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (found < 0 && !cache_valid[i]) found = i;
      end
      if (found < 0) begin
        // Evict the oldest stamp; pull any stamp ahead of the clock back to it.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (cache_stamp[i] > cache_clock) begin
            cache_stamp[i] = cache_clock;
            age            = '0;
          end else begin
            age = cache_clock - cache_stamp[i];
          end
          if (!have_victim || age > best_age) begin
            best_age    = age;
            found       = i;
            have_victim = 1'b1;
          end
        end
      end
      cache_tag[found]   = r.page_number;
      cache_valid[found] = 1'b1;
    end
    cache_stamp[found] = cache_clock;
    seg_full            = 32'(r.page_number) / PAGES_PER_SEGMENT;
    pis_full            = 32'(r.page_number) % PAGES_PER_SEGMENT;
    res.slot            = found[lpsc_pkg::SLOT_W-1:0];
    res.segment         = seg_full[lpsc_pkg::SEG_W-1:0];
    res.page_in_segment = pis_full[lpsc_pkg::PIS_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one transfer per call; valid stays high for the next call.
  // ---------------------------------------------------------------------------
  task automatic send_req(lpsc_pkg::req_t r);
    req_bus.valid <= 1'b1;
    req_bus.data  <= r;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    // The transfer happened at this edge; record what it must produce.
    expected_rsp_q.push_back(predict_cache_access(r));
  endtask

  // Drop valid and stay quiet for a number of cycles.
  task automatic idle_sender(int unsigned n);
    req_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic lpsc_pkg::req_t lookup_req(logic [lpsc_pkg::PAGE_W-1:0] page,
                                                logic [lpsc_pkg::GEN_W-1:0] gen,
                                                logic flush);
    lpsc_pkg::req_t r;
    r.mode        = lpsc_pkg::MODE_LOOKUP;
    r.page_number = page;
    r.generation  = gen;
    r.flush_flag  = flush;
    return r;
  endfunction

  function automatic lpsc_pkg::req_t clear_req(logic [lpsc_pkg::PAGE_W-1:0] page,
                                               logic [lpsc_pkg::GEN_W-1:0] gen,
                                               logic flush);
    lpsc_pkg::req_t r;
    r            = lookup_req(page, gen, flush);
    r.mode       = lpsc_pkg::MODE_CLEAR;
    return r;
  endfunction

  // Environment seen by the random requests: current pair and a small page
  // window, so most lookups hit, fill or evict instead of invalidating.
  logic [lpsc_pkg::GEN_W-1:0]  env_gen;
  logic                        env_flush;
  logic [lpsc_pkg::PAGE_W-1:0] env_base;

  function automatic lpsc_pkg::req_t make_random_req();
    int unsigned pick;
    logic [lpsc_pkg::PAGE_W-1:0] noise_page;
    pick       = $urandom_range(0, 99);
    noise_page = lpsc_pkg::PAGE_W'($urandom);
    if (pick < 4) begin
      return clear_req(noise_page, $urandom, 1'($urandom));
    end
    if (pick < 7) begin
      // Move to a new generation or flush state with a fresh page window.
      env_gen   = $urandom;
      env_flush = 1'($urandom);
      env_base  = lpsc_pkg::PAGE_W'($urandom);
    end
    if (pick >= 7 && pick < 15) begin
      return lookup_req(noise_page, env_gen, env_flush);
    end
    if (pick >= 15 && pick < 17) begin
      // Broken sequence: one request with a stray pair.
      return lookup_req(env_base + lpsc_pkg::PAGE_W'($urandom_range(0, WORK_SET_SIZE - 1)),
                        env_gen ^ (32'h1 << $urandom_range(0, lpsc_pkg::GEN_W - 1)),
                        env_flush);
    end
    return lookup_req(env_base + lpsc_pkg::PAGE_W'($urandom_range(0, WORK_SET_SIZE - 1)),
                      env_gen, env_flush);
  endfunction

  // Send random requests in bursts with gaps of up to max_gap cycles.
  task automatic send_random_stream(int unsigned n_items, int unsigned max_gap);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 16);
      for (int unsigned b = 0; b < burst && sent < n_items; b++) begin
        send_req(make_random_req());
        sent++;
      end
      gap = $urandom_range(0, max_gap);
      if (gap > 0) idle_sender(gap);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready runs, a full-speed mode and one long hold-off.
  // ---------------------------------------------------------------------------
  bit rsp_full_speed;
  bit hold_rsp;

  initial begin : rsp_receiver
    int unsigned run_left;
    bit          ready_level;
    run_left      = 0;
    ready_level   = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        // Hold off long enough that the block fills and stalls its input.
        rsp_bus.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (rsp_full_speed) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_level = ($urandom_range(0, 2) != 0);
          run_left    = $urandom_range(1, 8);
        end
        run_left--;
        rsp_bus.ready <= ready_level;
      end
    end
  end

  // Compare each result transfer with the oldest prediction, field by field.
  always @(posedge clk) begin : rsp_checker
    lpsc_pkg::rsp_t exp_rsp;
    lpsc_pkg::rsp_t act_rsp;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      act_rsp = rsp_bus.data;
      if (expected_rsp_q.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("ERROR: unexpected result hit=%0b slot=%0d inval=%0b seg=%0h pis=%0d",
                   act_rsp.hit, act_rsp.slot, act_rsp.was_invalidated,
                   act_rsp.segment, act_rsp.page_in_segment);
        end
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (act_rsp.hit !== exp_rsp.hit || act_rsp.slot !== exp_rsp.slot ||
            act_rsp.was_invalidated !== exp_rsp.was_invalidated ||
            act_rsp.segment !== exp_rsp.segment ||
            act_rsp.page_in_segment !== exp_rsp.page_in_segment) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("ERROR: result mismatch at %0t", $realtime);
            $display("  expected hit=%0b slot=%0d inval=%0b seg=%0h pis=%0d",
                     exp_rsp.hit, exp_rsp.slot, exp_rsp.was_invalidated,
                     exp_rsp.segment, exp_rsp.page_in_segment);
            $display("  actual   hit=%0b slot=%0d inval=%0b seg=%0h pis=%0d",
                     act_rsp.hit, act_rsp.slot, act_rsp.was_invalidated,
                     act_rsp.segment, act_rsp.page_in_segment);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill from reset (pair 0/0 matches, so no invalidation), cover the page
  // extremes and segment boundaries, hit once, then evict the oldest slots.
  task automatic test_fill_and_evict();
    send_req(lookup_req(31'h0000_0000, 32'h0, 1'b0));
    send_req(lookup_req(31'h7FFF_FFFF, 32'h0, 1'b0));
    send_req(lookup_req(31'd31, 32'h0, 1'b0));
    send_req(lookup_req(31'd32, 32'h0, 1'b0));
    send_req(lookup_req(31'd5, 32'h0, 1'b0));
    send_req(lookup_req(31'd6, 32'h0, 1'b0));
    send_req(lookup_req(31'h2AAA_AAAA, 32'h0, 1'b0));
    send_req(lookup_req(31'h5555_5555, 32'h0, 1'b0));
    send_req(lookup_req(31'h0000_0000, 32'h0, 1'b0));
    send_req(lookup_req(31'd100, 32'h0, 1'b0));
    send_req(lookup_req(31'd101, 32'h0, 1'b0));
    wait_drained();
  endtask

  // Invalidate on generation change, on flush change, and back to zero.
  task automatic test_invalidation();
    send_req(lookup_req(31'd0, 32'hFFFF_FFFF, 1'b0));
    send_req(lookup_req(31'd0, 32'hFFFF_FFFF, 1'b1));
    send_req(lookup_req(31'd0, 32'hFFFF_FFFF, 1'b1));
    send_req(lookup_req(31'd7, 32'h0, 1'b0));
    wait_drained();
  endtask

  // Clear mode empties slots but keeps the stored pair; its fields are ignored.
  task automatic test_clear_mode();
    send_req(lookup_req(31'd9, 32'h0, 1'b0));
    send_req(clear_req(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_req(lookup_req(31'd9, 32'h0, 1'b0));
    send_req(clear_req(31'h0, 32'h0, 1'b0));
    wait_drained();
  endtask

  // Hold the result side off while requests keep coming, then drain fully.
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    for (int i = 0; i < 12; i++) send_req(make_random_req());
    wait_drained();
  endtask

  // No idling on either side.
  task automatic test_back_to_back();
    rsp_full_speed = 1'b1;
    send_random_stream(100, 0);
    wait_drained();
    rsp_full_speed = 1'b0;
  endtask

  // Bulk random traffic with sender bursts and receiver stalls.
  task automatic test_random_traffic();
    send_random_stream(880, 12);
    wait_drained();
  endtask

  initial begin : main_seq
    error_count    = 0;
    report_count   = 0;
    rsp_full_speed = 1'b0;
    hold_rsp       = 1'b0;
    env_gen        = $urandom;
    env_flush      = 1'($urandom);
    env_base       = lpsc_pkg::PAGE_W'($urandom);
    cache_gen      = '0;
    cache_flush    = 1'b0;
    empty_all_slots();

    rst_n         <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_evict();
    test_invalidation();
    test_clear_mode();
    test_backpressure();
    test_back_to_back();
    test_random_traffic();

    // Let any stray late result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      error_count++;
      $display("ERROR: %0d results never arrived", expected_rsp_q.size());
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ lru_page_slot_cache.f @@
+incdir+rtl/core
rtl/core/lpsc_pkg.sv
rtl/core/lpsc_if.sv
rtl/core/lpsc_ram.sv
rtl/core/lpsc_seg_div.sv
rtl/core/lru_page_slot_cache.sv
tb/tb_top.sv
